### hdl/ltc_pkg.sv
// Package for the lexeme token classifier: sizes, class codes, keyword and
// operator tables, character tests and the structs passed between modules.
// Depends on nothing; every file of the block but ltc_checker imports it.
package ltc_pkg;

  // Identifier length limit and the number of table entries in use.
  localparam int MAX_ID_LENGTH  = 20;
  localparam int KEYWORD_COUNT  = 12;
  localparam int OPERATOR_COUNT = 16;

  localparam int KW_TABLE = 12;
  localparam int OP_TABLE = 16;
  localparam int KW_N = (KEYWORD_COUNT < KW_TABLE) ? KEYWORD_COUNT : KW_TABLE;
  localparam int OP_N = (OPERATOR_COUNT < OP_TABLE) ? OPERATOR_COUNT : OP_TABLE;
  localparam int KW_IDX_W = $clog2(KW_TABLE);
  localparam int OP_IDX_W = $clog2(OP_TABLE);

  // Table text is held right-justified in a word wide enough for the longest entry.
  localparam int TXT_CHARS = 9;
  localparam int TXT_BITS  = 8 * TXT_CHARS;

  // Character position counter, saturating at its all-ones value.
  localparam int POS_W = 5;
  typedef logic [POS_W-1:0] pos_t;
  localparam pos_t POS_MAX = '1;

  // Token class codes.
  typedef logic [4:0] class_t;
  localparam class_t CLASS_NUMBER  = 5'd0;
  localparam class_t CLASS_KW_BASE = 5'd1;
  localparam class_t CLASS_OP_BASE = 5'd13;
  localparam class_t CLASS_ID      = 5'd29;
  localparam class_t CLASS_BAD_ID  = 5'd30;
  localparam class_t CLASS_UNKNOWN = 5'd31;

  // Special characters.
  localparam logic [7:0] CHR_MINUS      = 8'h2D;
  localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;

  // Keyword table.
  localparam logic [TXT_BITS-1:0] KW_TEXT [KW_TABLE] = '{
    TXT_BITS'("program"), TXT_BITS'("declare"), TXT_BITS'("list"),
    TXT_BITS'("of"), TXT_BITS'("variables"), TXT_BITS'("size"),
    TXT_BITS'("values"), TXT_BITS'("integer"), TXT_BITS'("real"),
    TXT_BITS'("boolean"), TXT_BITS'("array"), TXT_BITS'("R1")
  };
  localparam int KW_LEN [KW_TABLE] = '{7, 7, 4, 2, 9, 4, 6, 7, 4, 7, 5, 2};

  // Operator table.
  localparam logic [TXT_BITS-1:0] OP_TEXT [OP_TABLE] = '{
    TXT_BITS'("+"), TXT_BITS'("-"), TXT_BITS'("*"), TXT_BITS'("/"),
    TXT_BITS'("("), TXT_BITS'(")"), TXT_BITS'("{"), TXT_BITS'("}"),
    TXT_BITS'("["), TXT_BITS'("]"), TXT_BITS'("&&&"), TXT_BITS'("|||"),
    TXT_BITS'(":"), TXT_BITS'(";"), TXT_BITS'(".."), TXT_BITS'("=")
  };
  localparam int OP_LEN [OP_TABLE] = '{1, 1, 1, 1, 1, 1, 1, 1,
                                       1, 1, 3, 3, 1, 1, 2, 1};

  // One classified lexeme as it travels through the queue.
  typedef struct packed {
    class_t      token_class;
    logic [15:0] line_number;
  } token_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Byte at position pos of a table entry of length len.
  function automatic logic [7:0] char_at(input logic [TXT_BITS-1:0] text,
                                         input int len, input pos_t pos);
    logic [TXT_BITS-1:0] lj;
    logic [7:0]          b;
    lj = text << (8 * (TXT_CHARS - len));
    b  = 8'h00;
    for (int j = 0; j < TXT_CHARS; j++) begin
      if (pos == POS_W'(j)) begin
        b = lj[TXT_BITS-1-8*j -: 8];
      end
    end
    return b;
  endfunction

  // True when the entry has byte c at position pos.
  function automatic logic entry_match(input logic [TXT_BITS-1:0] text,
                                       input int len, input pos_t pos,
                                       input logic [7:0] c);
    return ({1'b0, pos} < (POS_W+1)'(len)) && (char_at(text, len, pos) == c);
  endfunction

  // True when an entry of length len ends at position pos.
  function automatic logic entry_ends(input int len, input pos_t pos);
    return (({1'b0, pos} + (POS_W+1)'(1)) == (POS_W+1)'(len));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_id_start(input logic [7:0] c);
    return (c == CHR_UNDERSCORE) || is_letter(c);
  endfunction

endpackage

### hdl/lexeme_token_classifier.sv
// Lexeme token classifier: one character per request in, one token class
// per lexeme out.
// Input channel (chr_valid / chr_stall): char_code, last_char and
// line_number; last_char marks the final character of a lexeme. One
// character is accepted per cycle while the internal token queue has room.
// Output channel (tok_valid / tok_stall): token_class and line_number_out,
// one request for each lexeme, in lexeme order.
// Path of a token: the queue is written at the edge that accepts its last
// character, and the output register loads it when empty or being taken.
// Throughput is one character per cycle while the queue has room and one
// token per cycle while the receiver does not stall, set by the mask update
// in the front part and the output register in the back part.
// When the receiver stalls, the token holds in the output register and the
// queue absorbs up to two more tokens; after that chr_stall rises and every
// character waits, whether or not it ends a lexeme, until a token is taken.
// Synchronous reset clears the character position, the candidate masks, the
// flags, the queue and the output valid.
// Depends on ltc_pkg, ltc_front, ltc_fifo and ltc_back.
module lexeme_token_classifier (
  input  logic                clk,
  input  logic                rst,
  input  logic                chr_valid,
  output logic                chr_stall,
  input  logic [7:0]          char_code,
  input  logic                last_char,
  input  logic [15:0]         line_number,
  output logic                tok_valid,
  input  logic                tok_stall,
  output ltc_pkg::class_t     token_class,
  output logic [15:0]         line_number_out
);
  import ltc_pkg::*;

  fifo_stat_t fifo_stat;
  logic       push;
  logic       pop;
  token_t     push_token;
  token_t     pop_token;

  // Character intake and classification.
  ltc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .chr_valid   (chr_valid),
    .chr_stall   (chr_stall),
    .char_code   (char_code),
    .last_char   (last_char),
    .line_number (line_number),
    .fifo_stat   (fifo_stat),
    .push        (push),
    .push_token  (push_token)
  );

  // Token queue.
  ltc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .pop_token  (pop_token),
    .fifo_stat  (fifo_stat)
  );

  // Output register.
  ltc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .fifo_stat       (fifo_stat),
    .pop_token       (pop_token),
    .pop             (pop),
    .tok_valid       (tok_valid),
    .tok_stall       (tok_stall),
    .token_class     (token_class),
    .line_number_out (line_number_out)
  );

endmodule

### hdl/ltc_front.sv
// Front part of the lexeme token classifier: takes characters, narrows the
// keyword and operator candidate masks, tracks flags and classifies.
// Depends on ltc_pkg; pushes finished tokens into ltc_fifo.
module ltc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               chr_valid,
  output logic               chr_stall,
  input  logic [7:0]         char_code,
  input  logic               last_char,
  input  logic [15:0]        line_number,
  input  ltc_pkg::fifo_stat_t fifo_stat,
  output logic               push,
  output ltc_pkg::token_t    push_token
);
  import ltc_pkg::*;

  pos_t                char_position;
  logic [KW_TABLE-1:0] keyword_candidates;
  logic [OP_TABLE-1:0] operator_candidates;
  logic [7:0]          first_character;
  logic                number_flag;
  logic                identifier_ok;

  pos_t                char_position_next;
  logic [KW_TABLE-1:0] keyword_candidates_next;
  logic [OP_TABLE-1:0] operator_candidates_next;
  logic [7:0]          first_character_next;
  logic                number_flag_next;
  logic                identifier_ok_next;

  logic                accept;
  logic                kw_hit;
  logic                op_hit;
  logic [KW_IDX_W-1:0] kw_idx;
  logic [OP_IDX_W-1:0] op_idx;
  class_t              cls;

  // The front waits only when the queue has no room.
  assign chr_stall = fifo_stat.full;
  assign accept    = chr_valid && !fifo_stat.full;

  // Narrow the candidate masks with the current character.
  always_comb begin
    for (int i = 0; i < KW_TABLE; i++) begin
      if (i < KW_N) begin
        keyword_candidates_next[i] = keyword_candidates[i] &&
          entry_match(KW_TEXT[i], KW_LEN[i], char_position, char_code);
      end else begin
        keyword_candidates_next[i] = keyword_candidates[i];
      end
    end
    for (int i = 0; i < OP_TABLE; i++) begin
      if (i < OP_N) begin
        operator_candidates_next[i] = operator_candidates[i] &&
          entry_match(OP_TEXT[i], OP_LEN[i], char_position, char_code);
      end else begin
        operator_candidates_next[i] = operator_candidates[i];
      end
    end
  end

  // Update the first character, number flag and identifier flag.
  always_comb begin
    first_character_next = first_character;
    number_flag_next     = number_flag;
    identifier_ok_next   = identifier_ok;
    if (char_position == '0) begin
      first_character_next = char_code;
      number_flag_next     = is_digit(char_code);
      identifier_ok_next   = is_id_start(char_code);
    end else begin
      if ((char_position == POS_W'(1)) && (first_character == CHR_MINUS) &&
          is_digit(char_code)) begin
        number_flag_next = 1'b1;
      end
      if (!(({1'b0, char_position} < (POS_W+1)'(MAX_ID_LENGTH)) &&
            (is_id_start(char_code) || is_digit(char_code)))) begin
        identifier_ok_next = 1'b0;
      end
    end
    char_position_next = (char_position == POS_MAX) ? char_position
                                                    : char_position + POS_W'(1);
  end

  // Pick the first keyword and operator that end at this character.
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int i = KW_TABLE - 1; i >= 0; i--) begin
      if ((i < KW_N) && keyword_candidates_next[i] &&
          entry_ends(KW_LEN[i], char_position)) begin
        kw_hit = 1'b1;
        kw_idx = KW_IDX_W'(i);
      end
    end
    op_hit = 1'b0;
    op_idx = '0;
    for (int i = OP_TABLE - 1; i >= 0; i--) begin
      if ((i < OP_N) && operator_candidates_next[i] &&
          entry_ends(OP_LEN[i], char_position)) begin
        op_hit = 1'b1;
        op_idx = OP_IDX_W'(i);
      end
    end
  end

  // Class priority: number, keyword, operator, identifier, unrecognised.
  always_comb begin
    if (number_flag_next) begin
      cls = CLASS_NUMBER;
    end else if (kw_hit) begin
      cls = CLASS_KW_BASE + class_t'(kw_idx);
    end else if (op_hit) begin
      cls = CLASS_OP_BASE + class_t'(op_idx);
    end else if (is_id_start(first_character_next)) begin
      cls = identifier_ok_next ? CLASS_ID : CLASS_BAD_ID;
    end else begin
      cls = CLASS_UNKNOWN;
    end
  end

  assign push                   = accept && last_char;
  assign push_token.token_class = cls;
  assign push_token.line_number = line_number;

  // Per-lexeme state; a last character returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst || (accept && last_char)) begin
      char_position       <= '0;
      keyword_candidates  <= '1;
      operator_candidates <= '1;
      first_character     <= 8'h00;
      number_flag         <= 1'b0;
      identifier_ok       <= 1'b1;
    end else if (accept) begin
      char_position       <= char_position_next;
      keyword_candidates  <= keyword_candidates_next;
      operator_candidates <= operator_candidates_next;
      first_character     <= first_character_next;
      number_flag         <= number_flag_next;
      identifier_ok       <= identifier_ok_next;
    end
  end

endmodule

### hdl/ltc_fifo.sv
// Short token queue between the front and back parts of the classifier.
// Depends on ltc_pkg for the token struct, status struct and depth.
module ltc_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ltc_pkg::token_t     push_token,
  input  logic                pop,
  output ltc_pkg::token_t     pop_token,
  output ltc_pkg::fifo_stat_t fifo_stat
);
  import ltc_pkg::*;

  token_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign fifo_stat.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign fifo_stat.empty = (count == '0);
  assign pop_token       = mem[rd_ptr];

  // Storage is written at the write pointer; it needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_token;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

### hdl/ltc_back.sv
// Back part of the classifier: the output register that presents one token
// at a time to the receiver. Depends on ltc_pkg; drains ltc_fifo.
module ltc_back (
  input  logic                clk,
  input  logic                rst,
  input  ltc_pkg::fifo_stat_t fifo_stat,
  input  ltc_pkg::token_t     pop_token,
  output logic                pop,
  output logic                tok_valid,
  input  logic                tok_stall,
  output ltc_pkg::class_t     token_class,
  output logic [15:0]         line_number_out
);
  import ltc_pkg::*;

  // Load a new token when the register is empty or being taken.
  assign pop = !fifo_stat.empty && (!tok_valid || !tok_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (pop) begin
      tok_valid <= 1'b1;
    end else if (!tok_stall) begin
      tok_valid <= 1'b0;
    end
  end

  // Payload register; it holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (pop) begin
      token_class     <= pop_token.token_class;
      line_number_out <= pop_token.line_number;
    end
  end

endmodule

### hdl/ltc_checker.sv
// Port-level checker for the lexeme token classifier, bound to the top level.
// Depends only on the top level's ports.
module ltc_checker (
  input logic        clk,
  input logic        rst,
  input logic        chr_valid,
  input logic        chr_stall,
  input logic [7:0]  char_code,
  input logic        last_char,
  input logic [15:0] line_number,
  input logic        tok_valid,
  input logic        tok_stall,
  input logic [4:0]  token_class,
  input logic [15:0] line_number_out
);

  // A stalled token stays offered.
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_stall |=> tok_valid)
    else $error("token dropped while stalled");

  // A stalled token keeps its payload.
  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_stall |=> $stable(token_class) && $stable(line_number_out))
    else $error("token payload changed while stalled");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !tok_valid)
    else $error("token offered right after reset");

  // An accepted last character must be followed by an offered token.
  a_token_follows: assert property (@(posedge clk) disable iff (rst)
    chr_valid && !chr_stall && last_char |-> ##2 tok_valid)
    else $error("no token after a last character");

endmodule

bind lexeme_token_classifier ltc_checker u_ltc_checker (.*);
